FILE: rtl/scan_sample_unpack_scale_top_defines.svh
// Assertion macros used by the top-level RTL.
`ifndef SCAN_SAMPLE_UNPACK_SCALE_TOP_DEFINES_SVH
`define SCAN_SAMPLE_UNPACK_SCALE_TOP_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define SSSC_ASSERT_IMPLIES(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SSSC_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/sssc_pkg.sv
`default_nettype none
package sssc_pkg;

   // storage sizes that are understood
   localparam logic [3:0] STORE_ONE  = 4'd1;
   localparam logic [3:0] STORE_TWO  = 4'd2;
   localparam logic [3:0] STORE_FOUR = 4'd4;

   localparam int unsigned WORD_BITS = 32;

   // register indexes of the configuration port
   typedef enum logic [2:0] {
      REG_STORAGE_BYTES = 3'd0,
      REG_BIG_ENDIAN    = 3'd1,
      REG_SHIFT_RIGHT   = 3'd2,
      REG_DATA_BITS     = 3'd3,
      REG_SIGN_EXT      = 3'd4,
      REG_SCALE         = 3'd5,
      REG_OFFSET        = 3'd6
   } reg_index_type;

   localparam logic signed [63:0] VALUE_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] VALUE_MIN = {1'b1, {63{1'b0}}};

   typedef struct packed {
      logic [3:0]         storage_bytes;
      logic               big_endian;
      logic [4:0]         shift_right;
      logic [5:0]         data_bits;
      logic               sign_ext;
      logic signed [31:0] scale;
      logic signed [47:0] offset;
   } cfg_type;

   typedef struct packed {
      logic               invalid;
      logic signed [32:0] sample;
   } sample_type;

   typedef struct packed {
      logic               invalid;
      logic signed [63:0] prod;
   } prod_type;

endpackage
`default_nettype wire

FILE: rtl/sssc_unpack.sv
`default_nettype none
module sssc_unpack
   import sssc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [31:0] in_raw,
   output logic             out_valid,
   input  wire logic        out_ready,
   output sample_type       out_data
);

   logic       valid_ff;
   logic       valid_in;
   sample_type data_ff;
   sample_type data_in;
   logic [31:0] word;
   logic [31:0] shifted;
   logic [31:0] mask;
   logic [31:0] kept;
   logic [5:0]  n_eff;
   logic [4:0]  top_idx;
   logic        bad_size;
   logic        neg;

   // assemble the word in the stored byte order
   always_comb begin
      bad_size = 1'b0;
      word     = '0;
      case (cfg.storage_bytes)
         STORE_ONE: begin
            word = {24'd0, in_raw[7:0]};
         end
         STORE_TWO: begin
            word = cfg.big_endian ? {16'd0, in_raw[7:0], in_raw[15:8]}
                                  : {16'd0, in_raw[15:0]};
         end
         STORE_FOUR: begin
            word = cfg.big_endian ? {in_raw[7:0], in_raw[15:8], in_raw[23:16], in_raw[31:24]}
                                  : in_raw;
         end
         default: begin
            bad_size = 1'b1;
         end
      endcase
   end

   // shift, mask to the used bits, sign-extend
   always_comb begin
      shifted = word >> cfg.shift_right;
      n_eff   = (cfg.data_bits > 6'(WORD_BITS)) ? 6'(WORD_BITS) : cfg.data_bits;
      if (n_eff == 6'd0) begin
         mask = '0;
      end else if (n_eff == 6'(WORD_BITS)) begin
         mask = '1;
      end else begin
         mask = (32'd1 << n_eff[4:0]) - 32'd1;
      end
      kept    = shifted & mask;
      top_idx = n_eff[4:0] - 5'd1;
      neg     = cfg.sign_ext && (n_eff != 6'd0) && shifted[top_idx];
      data_in.invalid = bad_size;
      data_in.sample  = neg ? $signed({1'b1, kept | ~mask}) : $signed({1'b0, kept});
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/sssc_mul.sv
`default_nettype none
module sssc_mul
   import sssc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic signed [31:0] scale,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire sample_type         in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output prod_type                out_data
);

   logic               valid_ff;
   logic               valid_in;
   prod_type           data_ff;
   prod_type           data_in;
   logic signed [64:0] full_prod;

   // |sample| < 2^32 and |scale| <= 2^31: the product fits in 64 bits
   assign full_prod       = in_data.sample * scale;
   assign data_in.invalid = in_data.invalid;
   assign data_in.prod    = full_prod[63:0];

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/sssc_acc.sv
`default_nettype none
module sssc_acc
   import sssc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic signed [47:0] offset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire prod_type           in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic signed [63:0]      out_value,
   output logic                    out_invalid,
   output logic                    out_saturated
);

   logic               valid_ff;
   logic               valid_in;
   logic signed [63:0] value_ff;
   logic signed [63:0] value_in;
   logic               invalid_ff;
   logic               saturated_ff;
   logic               saturated_in;
   logic [64:0]        sum;
   logic               ovf;

   // add in 65 bits, clip when the top two bits disagree; an invalid item gives zero
   always_comb begin
      sum = {in_data.prod[63], in_data.prod} + {{17{offset[47]}}, offset};
      ovf = sum[64] != sum[63];
      if (in_data.invalid) begin
         value_in     = '0;
         saturated_in = 1'b0;
      end else if (ovf) begin
         value_in     = sum[64] ? VALUE_MIN : VALUE_MAX;
         saturated_in = 1'b1;
      end else begin
         value_in     = $signed(sum[63:0]);
         saturated_in = 1'b0;
      end
   end

   assign in_ready      = !valid_ff || out_ready;
   assign valid_in      = in_ready ? in_valid : valid_ff;
   assign out_valid     = valid_ff;
   assign out_value     = value_ff;
   assign out_invalid   = invalid_ff;
   assign out_saturated = saturated_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         value_ff     <= value_in;
         invalid_ff   <= in_data.invalid;
         saturated_ff <= saturated_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/scan_sample_unpack_scale_top.sv
// Each accepted item is registered by each stage in turn before its result reaches the rsp_ side.
// Throughput: one item per cycle while rsp_stall is low; each of the three stages (unpack, multiply,
// add and clip) holds one item and advances whenever the stage after it moves.
// Reset: synchronous, active high; empties all stages and loads the register
// defaults (2 bytes, little endian, no shift, 16 bits, unsigned, gain 1.0).
`default_nettype none
`include "scan_sample_unpack_scale_top_defines.svh"
module scan_sample_unpack_scale_top
   import sssc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [47:0] csr_data,
   // input items
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_raw_bytes,
   // result items
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [63:0] rsp_value,
   output logic             rsp_invalid,
   output logic             rsp_saturated
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       unp_ready;
   logic       unp_valid;
   sample_type unp_data;
   logic       mul_ready;
   logic       mul_valid;
   prod_type   mul_data;
   logic       acc_ready;

   // Registers take a write on any cycle; an index past the list is dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_STORAGE_BYTES: cfg_in.storage_bytes = csr_data[3:0];
            REG_BIG_ENDIAN:    cfg_in.big_endian    = csr_data[0];
            REG_SHIFT_RIGHT:   cfg_in.shift_right   = csr_data[4:0];
            REG_DATA_BITS:     cfg_in.data_bits     = csr_data[5:0];
            REG_SIGN_EXT:      cfg_in.sign_ext      = csr_data[0];
            REG_SCALE:         cfg_in.scale         = $signed(csr_data[31:0]);
            REG_OFFSET:        cfg_in.offset        = $signed(csr_data);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.storage_bytes <= STORE_TWO;
         cfg_ff.big_endian    <= 1'b0;
         cfg_ff.shift_right   <= 5'd0;
         cfg_ff.data_bits     <= 6'd16;
         cfg_ff.sign_ext      <= 1'b0;
         cfg_ff.scale         <= 32'sd65536;
         cfg_ff.offset        <= 48'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Stall the input only when every stage is occupied and the output is held.
   assign req_stall = !unp_ready;

   // Stage 1: assemble the word, shift, mask and sign-extend
   sssc_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (unp_ready),
      .in_raw    (req_raw_bytes),
      .out_valid (unp_valid),
      .out_ready (mul_ready),
      .out_data  (unp_data)
   );

   // Stage 2: multiply the sample by the Q16 gain
   sssc_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .scale     (cfg_ff.scale),
      .in_valid  (unp_valid),
      .in_ready  (mul_ready),
      .in_data   (unp_data),
      .out_valid (mul_valid),
      .out_ready (acc_ready),
      .out_data  (mul_data)
   );

   // Stage 3: add the offset, clip to 64 bits, hold the result for the taker
   sssc_acc u_acc (
      .clock         (clock),
      .reset         (reset),
      .offset        (cfg_ff.offset),
      .in_valid      (mul_valid),
      .in_ready      (acc_ready),
      .in_data       (mul_data),
      .out_valid     (rsp_valid),
      .out_ready     (!rsp_stall),
      .out_value     (rsp_value),
      .out_invalid   (rsp_invalid),
      .out_saturated (rsp_saturated)
   );

   // An item with a bad storage size carries a zero value and no clip flag.
   `SSSC_ASSERT_IMPLIES(a_invalid_zero, clock, reset, rsp_valid && rsp_invalid,
      rsp_value == 64'sd0 && !rsp_saturated, "invalid item with nonzero value")
   // A clipped value sits at one end of the range.
   `SSSC_ASSERT_IMPLIES(a_sat_extreme, clock, reset, rsp_valid && rsp_saturated,
      rsp_value == VALUE_MAX || rsp_value == VALUE_MIN, "clipped value not at range end")
   // Input stalls only when the pipeline is full and the output is held.
   `SSSC_ASSERT_IMPLIES(a_stall_full, clock, reset, req_stall,
      rsp_valid && rsp_stall && unp_valid && mul_valid, "input stalled with room left")

endmodule
`default_nettype wire
